FILE: rtl/core/iidl_pkg.sv
// package for the indexed insert/delete list core
// opcode, status and cell command types shared by the cells and the top level
`timescale 1ns / 1ps

package iidl_pkg;

  localparam int POS_W    = 6;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int PORT_VW  = 32;
  localparam int CNT_OUTW = 7;
  localparam int RD_GROUP = 8;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_GET    = 3'd3,
    OP_SET    = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_e;

  typedef enum logic [2:0] {
    CELL_NOP    = 3'd0,
    CELL_APPEND = 3'd1,
    CELL_INSERT = 3'd2,
    CELL_DELETE = 3'd3,
    CELL_SET    = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

FILE: rtl/core/iidl_cell.sv
// one storage cell of the list chain
// depends on iidl_pkg; takes data from either neighbour or the broadcast value
`timescale 1ns / 1ps

module iidl_cell import iidl_pkg::*; #(
  parameter int VW  = 32,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  cell_cmd_t     cmd_i,
  input  logic [CW-1:0] count_i,
  input  logic [VW-1:0] value_i,
  input  logic [VW-1:0] left_i,
  input  logic [VW-1:0] right_i,
  output logic [VW-1:0] data_o,
  output logic [VW-1:0] hit_o
);

  localparam int IW = (CW > POS_W) ? CW : POS_W;
  localparam logic [IW-1:0] IdxC = IW'(IDX);
  localparam logic [IW-1:0] NxtC = IW'(IDX + 1);

  logic [VW-1:0] data_q, data_d;
  logic [IW-1:0] pos_x, cnt_x;
  logic          at_pos;

  assign pos_x  = IW'(cmd_i.pos);
  assign cnt_x  = IW'(count_i);
  assign at_pos = (IdxC == pos_x);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_APPEND: begin
        if (IdxC == cnt_x) data_d = value_i;
      end
      CELL_INSERT: begin
        if (at_pos) data_d = value_i;
        else if (IdxC > pos_x && IdxC <= cnt_x) data_d = left_i;
      end
      CELL_DELETE: begin
        if (IdxC >= pos_x && NxtC < cnt_x) data_d = right_i;
      end
      CELL_SET: begin
        if (at_pos) data_d = value_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = at_pos ? data_q : '0;

endmodule

FILE: rtl/core/iidl_rdtree.sv
// registered or-tree that gathers the addressed cell for a get
// depends on iidl_pkg for the group size
`timescale 1ns / 1ps

module iidl_rdtree import iidl_pkg::*; #(
  parameter int VW = 32,
  parameter int N  = 64
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] hit_i [N],
  output logic [VW-1:0] data_o
);

  localparam int NG = (N + RD_GROUP - 1) / RD_GROUP;

  logic [VW-1:0] part_q [NG];
  logic [VW-1:0] part_d [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < RD_GROUP; k++) begin
        if (g * RD_GROUP + k < N) part_d[g] = part_d[g] | hit_i[g * RD_GROUP + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < NG; g++) part_q[g] <= part_d[g];
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NG; g++) data_o = data_o | part_q[g];
  end

endmodule

FILE: rtl/core/indexed_insert_delete_list_core.sv
// top level of the indexed insert/delete list: request decode, count, chain of cells
// depends on iidl_pkg, iidl_cell and iidl_rdtree
//
//   channel | signals                                    | direction
//   in      | in_valid_i/in_ready_o, opcode, position,   | request beat in
//           | item_value                                 |
//   out     | out_valid_o/out_ready_i, read_value,       | result beat out
//           | status, entry_count                        |
//
// on each request the accept edge updates all cells in parallel and registers the read
// partials; the partials are folded into the result register once no earlier result beat waits
// a new request is taken while a result beat still waits for out_ready_i
// reset clears the count and the handshake state; cell contents are left undefined
`timescale 1ns / 1ps

module indexed_insert_delete_list_core import iidl_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [PORT_VW-1:0]  item_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PORT_VW-1:0]  read_value_o,
  output logic [ST_W-1:0]     status_o,
  output logic [CNT_OUTW-1:0] entry_count_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = (VALUE_WIDTH < PORT_VW) ? VALUE_WIDTH : PORT_VW;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            in_acc;
  logic            pos_ok, full;
  st_e             st_d, st_q;
  logic            get_d, get_q;
  cell_cmd_t       cmd;
  logic [SW-1:0]   value;
  logic [SW-1:0]   cell_data [CAPACITY];
  logic [SW-1:0]   cell_hit  [CAPACITY];
  logic [SW-1:0]   rd_data;
  logic            out_valid_q;
  logic [SW-1:0]   read_value_q;
  st_e             status_q;
  logic [CW-1:0]   entry_count_q;
  logic            out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign value      = SW'(item_value_i);
  assign pos_ok     = CMPW'(position_i) < CMPW'(count_q);
  assign full       = (count_q == CapC);

  always_comb begin
    st_d    = ST_DONE;
    get_d   = 1'b0;
    count_d = count_q;
    cmd.pos = position_i;
    cmd.op  = CELL_NOP;
    case (op_e'(opcode_i))
      OP_APPEND: begin
        if (full) st_d = ST_FULL;
        else begin
          cmd.op  = CELL_APPEND;
          count_d = count_q + 1'b1;
        end
      end
      OP_INSERT: begin
        if (!pos_ok) st_d = ST_RANGE;
        else if (full) st_d = ST_FULL;
        else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!pos_ok) st_d = ST_RANGE;
        else begin
          cmd.op  = CELL_DELETE;
          count_d = count_q - 1'b1;
        end
      end
      OP_GET: begin
        if (!pos_ok) st_d = ST_RANGE;
        else get_d = 1'b1;
      end
      OP_SET: begin
        if (!pos_ok) st_d = ST_RANGE;
        else cmd.op = CELL_SET;
      end
      default: st_d = ST_DONE;
    endcase
    if (!in_acc) cmd.op = CELL_NOP;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [SW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[g+1];
    end
    iidl_cell #(
      .VW (SW),
      .CW (CW),
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .count_i(count_q),
      .value_i(value),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g]),
      .hit_o  (cell_hit[g])
    );
  end

  iidl_rdtree #(
    .VW(SW),
    .N (CAPACITY)
  ) u_rdtree (
    .clk_i (clk_i),
    .en_i  (in_acc),
    .hit_i (cell_hit),
    .data_o(rd_data)
  );

  assign out_load = (state_q == S_READ) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_READ;
      S_READ:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) count_q <= count_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st_q  <= st_d;
      get_q <= get_d;
    end
    if (out_load) begin
      read_value_q  <= get_q ? rd_data : '0;
      status_q      <= st_q;
      entry_count_q <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = PORT_VW'(read_value_q);
  assign status_o      = status_q;
  assign entry_count_o = CNT_OUTW'(entry_count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count above capacity");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && opcode_i == OP_APPEND && !full |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the count");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_DONE |-> read_value_q == '0)
    else $error("read data on a failed request");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o ##1 $stable(count_q))
    else $error("second beat taken while busy");

endmodule

FILE: dv/tb_top.sv
// self-checking bench for indexed_insert_delete_list_core: a shadow list predicts every
// result beat; random gaps on both handshakes; needs iidl_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_top import iidl_pkg::*;;

  localparam int          LIST_DEPTH   = 64;
  localparam int          RANDOM_ITEMS = 1050;
  localparam logic [OP_W-1:0] OP_LAST_CODE = '1;

  typedef struct {
    logic [OP_W-1:0]    opcode;
    logic [POS_W-1:0]   position;
    logic [PORT_VW-1:0] value;
  } request_t;

  typedef struct {
    logic [PORT_VW-1:0]  read_value;
    logic [ST_W-1:0]     status;
    logic [CNT_OUTW-1:0] entry_count;
  } result_t;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     opcode_i      = '0;
  logic [POS_W-1:0]    position_i    = '0;
  logic [PORT_VW-1:0]  item_value_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [PORT_VW-1:0]  read_value_o;
  logic [ST_W-1:0]     status_o;
  logic [CNT_OUTW-1:0] entry_count_o;

  request_t            request_q[$];
  result_t             results_q[$];
  request_t            in_flight;
  result_t             want;
  logic [PORT_VW-1:0]  list_mem[LIST_DEPTH];
  int unsigned         list_count    = 0;
  int unsigned         plan_count    = 0;
  int unsigned         counted       = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         gap_left      = 0;
  int unsigned         stall_left    = 0;
  int unsigned         in_calm       = 0;
  int unsigned         out_calm      = 0;

  indexed_insert_delete_list_core #(
    .CAPACITY    (LIST_DEPTH),
    .VALUE_WIDTH (PORT_VW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned count_after(request_t req, int unsigned cnt);
    case (req.opcode)
      OP_APPEND: return (cnt < LIST_DEPTH) ? cnt + 1 : cnt;
      OP_INSERT: return (req.position < cnt && cnt < LIST_DEPTH) ? cnt + 1 : cnt;
      OP_DELETE: return (req.position < cnt) ? cnt - 1 : cnt;
      default:   return cnt;
    endcase
  endfunction

  function automatic result_t apply_request(request_t req);
    result_t     res;
    int unsigned k;
    res.read_value = '0;
    res.status     = ST_DONE;
    case (req.opcode)
      OP_APPEND: begin
        if (list_count >= LIST_DEPTH) res.status = ST_FULL;
        else list_mem[list_count] = req.value;
      end
      OP_INSERT: begin
        if (req.position >= list_count) begin
          res.status = ST_RANGE;
        end else if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = list_count; k > req.position; k--) list_mem[k] = list_mem[k-1];
          list_mem[req.position] = req.value;
        end
      end
      OP_DELETE: begin
        if (req.position >= list_count) res.status = ST_RANGE;
        else for (k = req.position; k + 1 < list_count; k++) list_mem[k] = list_mem[k+1];
      end
      OP_GET: begin
        if (req.position >= list_count) res.status = ST_RANGE;
        else res.read_value = list_mem[req.position];
      end
      OP_SET: begin
        if (req.position >= list_count) res.status = ST_RANGE;
        else list_mem[req.position] = req.value;
      end
      default: ;
    endcase
    list_count      = count_after(req, list_count);
    res.entry_count = CNT_OUTW'(list_count);
    return res;
  endfunction

  // mostly zero, some short, a few long, with occasional idle-free stretches
  function automatic int unsigned draw_idle(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic request_t make_request(traffic_e mode);
    request_t    req;
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  req.opcode = (r < 50) ? OP_APPEND : OP_INSERT;
      MODE_DRAIN: req.opcode = (r < 80) ? OP_DELETE : (r < 90) ? OP_GET : OP_SET;
      default: begin
        if (r < 20)      req.opcode = OP_APPEND;
        else if (r < 40) req.opcode = OP_INSERT;
        else if (r < 60) req.opcode = OP_DELETE;
        else if (r < 80) req.opcode = OP_GET;
        else             req.opcode = OP_SET;
      end
    endcase
    if ($urandom_range(0, 99) < 4)
      req.opcode = OP_W'($urandom_range(int'(OP_SET) + 1, int'(OP_LAST_CODE)));
    if (plan_count > 0 && $urandom_range(0, 9) < 8)
      req.position = POS_W'($urandom_range(0, plan_count - 1));
    else
      req.position = POS_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0)      req.value = '0;
    else if (r == 1) req.value = '1;
    else             req.value = $urandom;
    return req;
  endfunction

  task automatic plan_request(request_t req);
    request_q.push_back(req);
    plan_count = count_after(req, plan_count);
    if (req.opcode <= OP_SET) counted++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) results_q.push_back(apply_request(in_flight));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_flight     = request_q.pop_front();
          in_valid_i   <= 1'b1;
          opcode_i     <= in_flight.opcode;
          position_i   <= in_flight.position;
          item_value_i <= in_flight.value;
          gap_left      = draw_idle(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (results_q.size() == 0) begin
          $error("result beat with no request pending");
          mismatch_count++;
        end else begin
          want = results_q.pop_front();
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value_o);
            mismatch_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_count++;
          end
          if (entry_count_o !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left   = draw_idle(out_calm);
      end
    end
  end

  initial begin
    int unsigned seg;
    int unsigned span;
    traffic_e    mode;

    // empty store, edges of the list, spare opcodes
    plan_request('{OP_GET,    6'd0,  32'h0000_0000});
    plan_request('{OP_DELETE, 6'd63, 32'hFFFF_FFFF});
    plan_request('{OP_INSERT, 6'd0,  32'h1111_1111});
    plan_request('{OP_SET,    6'd5,  32'h2222_2222});
    plan_request('{OP_APPEND, 6'd63, 32'hFFFF_FFFF});
    plan_request('{OP_APPEND, 6'd0,  32'h0000_0000});
    plan_request('{OP_APPEND, 6'd21, 32'h1234_5678});
    plan_request('{OP_INSERT, 6'd0,  32'hA5A5_A5A5});
    plan_request('{OP_INSERT, 6'd3,  32'h5A5A_5A5A});
    plan_request('{OP_GET,    6'd0,  32'h0000_0000});
    plan_request('{OP_GET,    6'd4,  32'hFFFF_FFFF});
    plan_request('{OP_GET,    6'd5,  32'h0000_0000});
    plan_request('{OP_SET,    6'd4,  32'h8000_0000});
    plan_request('{OP_GET,    6'd4,  32'h0000_0000});
    plan_request('{OP_DELETE, 6'd0,  32'h0000_0000});
    plan_request('{OP_DELETE, 6'd3,  32'h0000_0000});
    plan_request('{OP_SET + 3'd1, 6'd63, 32'hFFFF_FFFF});
    plan_request('{OP_LAST_CODE - 3'd1, 6'd1, 32'h0000_0001});
    plan_request('{OP_LAST_CODE, 6'd63, 32'hFFFF_FFFF});
    plan_request('{OP_GET,    6'd63, 32'h0000_0000});
    plan_request('{OP_DELETE, 6'd1,  32'h0000_0000});
    plan_request('{OP_DELETE, 6'd0,  32'h0000_0000});
    plan_request('{OP_DELETE, 6'd0,  32'h0000_0000});

    // random segments: fill to full, drain to empty, or mixed traffic
    seg = 0;
    while (counted < RANDOM_ITEMS) begin
      if (seg == 0)      mode = MODE_FILL;
      else if (seg == 1) mode = MODE_DRAIN;
      else begin
        span = $urandom_range(0, 3);
        mode = (span == 0) ? MODE_FILL : (span == 1) ? MODE_DRAIN : MODE_MIXED;
      end
      case (mode)
        MODE_FILL: begin
          while (plan_count < LIST_DEPTH) plan_request(make_request(MODE_FILL));
          repeat (5) plan_request(make_request(MODE_FILL));
          repeat (5) plan_request(make_request(MODE_MIXED));
        end
        MODE_DRAIN: begin
          while (plan_count > 0) plan_request(make_request(MODE_DRAIN));
          repeat (3) plan_request(make_request(MODE_MIXED));
        end
        default: begin
          span = $urandom_range(20, 80);
          repeat (span) plan_request(make_request(MODE_MIXED));
        end
      endcase
      seg++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (results_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && results_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/iidl_pkg.sv
rtl/core/iidl_cell.sv
rtl/core/iidl_rdtree.sv
rtl/core/indexed_insert_delete_list_core.sv
dv/tb_top.sv
